FILE: design/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is low
`define GRCM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define GRCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/grcm_pkg.sv
// package for the gradient color ramp map: item types, register codes, helpers
// no dependencies
package grcm_pkg;

    localparam int MAX_STOPS_DEF  = 8;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int NUM_STOP_WORDS = 8;
    localparam int CFG_IDX_W      = 3;

    localparam logic [3:0]  STOP_COUNT_RST = 4'd2;
    localparam logic [63:0] STOPS_01_RST   = 64'hFFFF_FFFF_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_COUNT = 3'd0,
        CFG_STOPS_01   = 3'd1,
        CFG_STOPS_23   = 3'd2,
        CFG_STOPS_45   = 3'd3,
        CFG_STOPS_67   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       no_segment;
    } t_pix_out;

    // colors of the chosen segment ends and the flags that ride with them
    typedef struct packed {
        logic [23:0] lo_rgb;
        logic [23:0] hi_rgb;
        logic        nseg;
        logic        neg;
    } t_seg_ctx;

    typedef logic [NUM_STOP_WORDS-1:0][31:0] t_stop_words;

    function automatic logic [9:0] times3(input logic [7:0] p);
        return {1'b0, p, 1'b0} + 10'(p);
    endfunction

endpackage

FILE: design/grcm_seg.sv
// segment search stage: brightness sum, first matching stop, numerator and span
// depends on grcm_pkg
module grcm_seg import grcm_pkg::*; #(
    parameter int MAX_STOPS = MAX_STOPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_pix_in     i_item,
    input  logic [3:0]  i_stop_count,
    input  t_stop_words i_stops,
    output logic        o_valid,
    output t_seg_ctx    o_ctx,
    output logic [9:0]  o_mag,
    output logic [9:0]  o_den
);

    localparam int SW = $clog2(MAX_STOPS);
    localparam logic [3:0] MaxN = 4'(MAX_STOPS);

    logic [9:0]         sum;
    logic [3:0]         cnt;
    logic               found;
    logic [SW-1:0]      sel;
    logic [SW-1:0]      sel_m1;
    logic [31:0]        w_lo;
    logic [31:0]        w_hi;
    logic signed [10:0] num;
    t_seg_ctx           n_ctx;
    logic [9:0]         n_mag;
    logic [9:0]         n_den;

    logic               r_valid;
    t_seg_ctx           r_ctx;
    logic [9:0]         r_mag;
    logic [9:0]         r_den;

    always_comb begin
        sum = 10'(i_item.red_in) + 10'(i_item.green_in) + 10'(i_item.blue_in);
        cnt = (i_stop_count > MaxN) ? MaxN : i_stop_count;
        found = 1'b0;
        sel = '0;
        for (int i = 1; i < MAX_STOPS; i++) begin
            if (!found && 4'(i) < cnt && sum <= times3(i_stops[i][31:24])) begin
                found = 1'b1;
                sel = SW'(i);
            end
        end
        sel_m1 = sel - 1'b1;
        w_lo = i_stops[3'(sel_m1)];
        w_hi = i_stops[3'(sel)];
        n_ctx.nseg = !found;
        n_ctx.hi_rgb = w_hi[23:0];
        if (w_hi[31:24] <= w_lo[31:24]) begin
            // flat or descending segment takes the upper color
            n_ctx.lo_rgb = w_hi[23:0];
            num = '0;
            n_den = 10'd1;
        end else begin
            n_ctx.lo_rgb = w_lo[23:0];
            num = $signed({1'b0, sum}) - $signed({1'b0, times3(w_lo[31:24])});
            n_den = times3(w_hi[31:24] - w_lo[31:24]);
        end
        n_ctx.neg = num[10];
        n_mag = num[10] ? 10'(-num) : num[9:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctx <= n_ctx;
            r_mag <= n_mag;
            r_den <= n_den;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_mag   = r_mag;
    assign o_den   = r_den;

endmodule

FILE: design/grcm_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on grcm_pkg
module grcm_div import grcm_pkg::*; #(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  t_seg_ctx                i_ctx,
    input  logic [9:0]              i_mag,
    input  logic [9:0]              i_den,
    output logic                    o_valid,
    output t_seg_ctx                o_ctx,
    output logic [FRACTION_BITS+9:0] o_q
);

    localparam int QW = FRACTION_BITS + 10;

    logic [QW:0]     c_v;
    t_seg_ctx        c_ctx [QW+1];
    logic [9:0]      c_rem [QW+1];
    logic [9:0]      c_den [QW+1];
    logic [QW-1:0]   c_n   [QW+1];
    logic [QW-1:0]   c_q   [QW+1];

    logic [10:0]     trial [QW];
    logic [QW-1:0]   ge;
    logic [9:0]      n_rem [QW];
    logic [QW-1:0]   n_n   [QW];
    logic [QW-1:0]   n_q   [QW];

    logic [QW-1:0]   r_v;
    t_seg_ctx        r_ctx [QW];
    logic [9:0]      r_rem [QW];
    logic [9:0]      r_den [QW];
    logic [QW-1:0]   r_n   [QW];
    logic [QW-1:0]   r_q   [QW];

    always_comb begin
        c_v[0]   = i_valid;
        c_ctx[0] = i_ctx;
        c_rem[0] = '0;
        c_den[0] = i_den;
        c_n[0]   = {i_mag, {FRACTION_BITS{1'b0}}};
        c_q[0]   = '0;
        for (int k = 1; k <= QW; k++) begin
            c_v[k]   = r_v[k-1];
            c_ctx[k] = r_ctx[k-1];
            c_rem[k] = r_rem[k-1];
            c_den[k] = r_den[k-1];
            c_n[k]   = r_n[k-1];
            c_q[k]   = r_q[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            trial[k] = {c_rem[k], c_n[k][QW-1]};
            ge[k]    = trial[k] >= {1'b0, c_den[k]};
            n_rem[k] = ge[k] ? 10'(trial[k] - {1'b0, c_den[k]}) : trial[k][9:0];
            n_n[k]   = c_n[k] << 1;
            n_q[k]   = {c_q[k][QW-2:0], ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= c_v[QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_ctx[k] <= c_ctx[k];
                r_rem[k] <= n_rem[k];
                r_den[k] <= c_den[k];
                r_n[k]   <= n_n[k];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_valid = c_v[QW];
    assign o_ctx   = c_ctx[QW];
    assign o_q     = c_q[QW];

endmodule

FILE: design/grcm_lerp.sv
// interpolation: signed portion, per-channel multiply, round toward zero, clamp
// depends on grcm_pkg
module grcm_lerp import grcm_pkg::*; #(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  t_seg_ctx                 i_ctx,
    input  logic [FRACTION_BITS+9:0] i_q,
    output logic                     o_valid,
    output t_pix_out                 o_item
);

    localparam int PW = FRACTION_BITS + 11;
    localparam int MW = PW + 9;
    localparam int SW = PW + 10;
    localparam logic signed [SW-1:0] RoundAdj = SW'((1 << FRACTION_BITS) - 1);

    logic                 r1_v;
    t_seg_ctx             r1_ctx;
    logic signed [PW-1:0] r1_port;
    logic signed [PW-1:0] n1_port;

    logic                 r2_v;
    logic                 r2_nseg;
    logic [7:0]           r2_a    [3];
    logic signed [MW-1:0] r2_prod [3];
    logic [7:0]           n2_a    [3];
    logic [7:0]           n2_b    [3];
    logic signed [8:0]    diff    [3];
    logic signed [MW-1:0] n2_prod [3];

    logic signed [SW-1:0] s       [3];
    logic signed [SW-1:0] t       [3];
    logic [7:0]           clamped [3];
    t_pix_out             n_out;

    logic                 r_out_v;
    t_pix_out             r_out;

    assign n1_port = i_ctx.neg ? -$signed({1'b0, i_q}) : $signed({1'b0, i_q});

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n2_a[c]    = r1_ctx.lo_rgb[23-8*c -: 8];
            n2_b[c]    = r1_ctx.hi_rgb[23-8*c -: 8];
            diff[c]    = $signed({1'b0, n2_b[c]}) - $signed({1'b0, n2_a[c]});
            n2_prod[c] = MW'(diff[c]) * MW'(r1_port);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s[c] = $signed(SW'({r2_a[c], {FRACTION_BITS{1'b0}}})) + SW'(r2_prod[c]);
            // truncate toward zero on the final scale-down
            if (s[c] < 0) begin
                s[c] = s[c] + RoundAdj;
            end
            t[c] = s[c] >>> FRACTION_BITS;
            if (t[c] < 0) begin
                clamped[c] = 8'd0;
            end else if (t[c] > SW'(255)) begin
                clamped[c] = 8'd255;
            end else begin
                clamped[c] = t[c][7:0];
            end
        end
        n_out.no_segment = r2_nseg;
        n_out.red_out    = r2_nseg ? 8'd0 : clamped[0];
        n_out.green_out  = r2_nseg ? 8'd0 : clamped[1];
        n_out.blue_out   = r2_nseg ? 8'd0 : clamped[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r_out_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ctx  <= i_ctx;
            r1_port <= n1_port;
            r2_nseg <= r1_ctx.nseg;
            for (int c = 0; c < 3; c++) begin
                r2_a[c]    <= n2_a[c];
                r2_prod[c] <= n2_prod[c];
            end
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

endmodule

FILE: design/gradient_color_ramp_map.sv
// top level of the gradient color ramp map: config registers and pipeline
// depends on grcm_pkg, grcm_seg, grcm_div, grcm_lerp
//
//  channel  direction  handshake                  payload
//  in       to block   i_in_valid / o_in_stall    i_in_item  (t_pix_in)
//  out      from block o_out_valid / i_out_stall  o_out_item (t_pix_out)
//  cfg      to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one item enters per cycle while the output is not stalled; the pipeline has
// one search stage, FRACTION_BITS + 10 divider stages and three interpolation stages
// the divider's one-bit-per-stage chain sets the depth
// reset clears all valid bits and loads the register reset values
// a stalled, valid output freezes the whole pipeline, bubbles included
module gradient_color_ramp_map import grcm_pkg::*; #(
    parameter int MAX_STOPS     = MAX_STOPS_DEF,
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_pix_in              i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_pix_out             o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    logic        en;
    logic [3:0]  r_stop_count;
    logic [63:0] r_stops [4];
    t_stop_words stop_words;

    logic        seg_v;
    t_seg_ctx    seg_ctx;
    logic [9:0]  seg_mag;
    logic [9:0]  seg_den;

    logic                     div_v;
    t_seg_ctx                 div_ctx;
    logic [FRACTION_BITS+9:0] div_q;

    assign en          = !o_out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= STOP_COUNT_RST;
            r_stops[0]   <= STOPS_01_RST;
            r_stops[1]   <= '0;
            r_stops[2]   <= '0;
            r_stops[3]   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STOP_COUNT: r_stop_count <= i_cfg_data[3:0];
                CFG_STOPS_01:   r_stops[0]   <= i_cfg_data;
                CFG_STOPS_23:   r_stops[1]   <= i_cfg_data;
                CFG_STOPS_45:   r_stops[2]   <= i_cfg_data;
                CFG_STOPS_67:   r_stops[3]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            stop_words[2*k]   = r_stops[k][31:0];
            stop_words[2*k+1] = r_stops[k][63:32];
        end
    end

    grcm_seg #(.MAX_STOPS(MAX_STOPS)) u_seg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_in_valid),
        .i_item       (i_in_item),
        .i_stop_count (r_stop_count),
        .i_stops      (stop_words),
        .o_valid      (seg_v),
        .o_ctx        (seg_ctx),
        .o_mag        (seg_mag),
        .o_den        (seg_den)
    );

    grcm_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (seg_v),
        .i_ctx   (seg_ctx),
        .i_mag   (seg_mag),
        .i_den   (seg_den),
        .o_valid (div_v),
        .o_ctx   (div_ctx),
        .o_q     (div_q)
    );

    grcm_lerp #(.FRACTION_BITS(FRACTION_BITS)) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_v),
        .i_ctx   (div_ctx),
        .i_q     (div_q),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule

FILE: design/grcm_chk.sv
// port-level checker for the gradient color ramp map, bound to the top level
// depends on grcm_pkg and assert_macros.svh
`include "assert_macros.svh"

module grcm_chk import grcm_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_pix_out o_out_item
);

    // a held item does not change under stall
    `GRCM_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item), "output item changed while stalled")

    // input side is held back only by a stalled, occupied output
    `GRCM_ASSERT_ALWAYS(a_in_stall_cause, i_clk, o_in_stall |-> o_out_valid && i_out_stall, "input stalled without output backpressure")

    // no segment means black
    `GRCM_ASSERT(a_nseg_black, i_clk, i_rst_n, o_out_valid && o_out_item.no_segment |-> o_out_item.red_out == 8'd0 && o_out_item.green_out == 8'd0 && o_out_item.blue_out == 8'd0, "no-segment item carries color")

    // nothing comes out right after reset
    `GRCM_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "output valid right after reset")

endmodule

bind gradient_color_ramp_map grcm_chk u_grcm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

FILE: tb/gradient_color_ramp_map_test.sv
// testbench for the gradient color ramp map: random and directed pixels, own ramp predictor
// depends on grcm_pkg and gradient_color_ramp_map
`timescale 1ns / 1ps

module gradient_color_ramp_map_test;
    import grcm_pkg::*;

    localparam int FRAC = 8;
    localparam int LATENCY = FRAC + 14;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_pix_in              i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_pix_out             o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;

    gradient_color_ramp_map dut (.*);

    always #2 i_clk = ~i_clk;

    // ramp settings as the predictor sees them
    logic [3:0]  ramp_count;
    logic [63:0] ramp_regs [4];

    t_pix_in  pixel_queue [$];
    t_pix_out color_queue [$];
    int       mismatches = 0;
    bit       in_gaps = 1'b1;
    bit       out_gaps = 1'b1;
    int       hold_cycles = 0;

    function automatic logic [31:0] stop_of(int k);
        logic [63:0] r;
        r = ramp_regs[k / 2];
        return (k % 2) ? r[63:32] : r[31:0];
    endfunction

    function automatic t_pix_out map_pixel(t_pix_in px);
        t_pix_out res;
        int sum, n, p0, p1, num, den, frac_pos, a, b, q;
        logic [31:0] lo, hi;
        res = '0;
        sum = px.red_in + px.green_in + px.blue_in;
        n = (ramp_count > 8) ? 8 : ramp_count;
        for (int i = 1; i < n; i++) begin
            lo = stop_of(i - 1);
            hi = stop_of(i);
            p0 = lo[31:24];
            p1 = hi[31:24];
            if (sum > 3 * p1) continue;
            for (int ch = 0; ch < 3; ch++) begin
                a = (lo >> (16 - 8 * ch)) & 8'hff;
                b = (hi >> (16 - 8 * ch)) & 8'hff;
                if (p1 <= p0) begin
                    q = b;
                end else begin
                    num = sum - 3 * p0;
                    den = 3 * (p1 - p0);
                    frac_pos = (num * (1 << FRAC)) / den;
                    q = (a * (1 << FRAC) + (b - a) * frac_pos) / (1 << FRAC);
                    if (q < 0) q = 0;
                    if (q > 255) q = 255;
                end
                case (ch)
                    0: res.red_out = q[7:0];
                    1: res.green_out = q[7:0];
                    default: res.blue_out = q[7:0];
                endcase
            end
            return res;
        end
        res.no_segment = 1'b1;
        return res;
    endfunction

    // driver: the queue head is the item on the port until it is accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                color_queue.push_back(map_pixel(i_in_item));
                void'(pixel_queue.pop_front());
            end
            if ((!i_in_valid || !o_in_stall)) begin
                if (pixel_queue.size() > 0 && !(in_gaps && $urandom_range(99) < 20)) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= pixel_queue[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (color_queue.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, o_out_item);
                    mismatches++;
                end else begin
                    t_pix_out exp_c;
                    exp_c = color_queue.pop_front();
                    if (exp_c !== o_out_item) begin
                        $display("%0t: expected %h (r %0d g %0d b %0d n %0b) got %h",
                                 $time, exp_c, exp_c.red_out, exp_c.green_out,
                                 exp_c.blue_out, exp_c.no_segment, o_out_item);
                        mismatches++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= out_gaps && ($urandom_range(99) < 20);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_STOP_COUNT: ramp_count = val[3:0];
            CFG_STOPS_01:   ramp_regs[0] = val;
            CFG_STOPS_23:   ramp_regs[1] = val;
            CFG_STOPS_45:   ramp_regs[2] = val;
            default:        ramp_regs[3] = val;
        endcase
    endtask

    task automatic drain();
        while (pixel_queue.size() != 0 || i_in_valid || color_queue.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_stop(int pos);
        return {pos[7:0], 24'($urandom)};
    endfunction

    // ascending stops with random colors, sometimes equal or descending positions
    task automatic random_ramp(int cnt);
        logic [31:0] s [8];
        int pos;
        pos = $urandom_range(60);
        for (int k = 0; k < 8; k++) begin
            s[k] = rand_stop(pos);
            if ($urandom_range(9) == 0) pos = pos - $urandom_range(20);
            else if ($urandom_range(9) != 0) pos = pos + $urandom_range(70);
            if (pos > 255) pos = 255;
            if (pos < 0) pos = 0;
        end
        write_reg(CFG_STOPS_01, {s[1], s[0]});
        write_reg(CFG_STOPS_23, {s[3], s[2]});
        write_reg(CFG_STOPS_45, {s[5], s[4]});
        write_reg(CFG_STOPS_67, {s[7], s[6]});
        write_reg(CFG_STOP_COUNT, 4'(cnt));
    endtask

    function automatic t_pix_in rand_pixel();
        return t_pix_in'($urandom);
    endfunction

    initial begin
        ramp_count = STOP_COUNT_RST;
        ramp_regs[0] = STOPS_01_RST;
        ramp_regs[1] = '0;
        ramp_regs[2] = '0;
        ramp_regs[3] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset ramp, extremes of the pixel
        pixel_queue.push_back('{8'd0, 8'd0, 8'd0});
        pixel_queue.push_back('{8'd255, 8'd255, 8'd255});
        pixel_queue.push_back('{8'd255, 8'd0, 8'd0});
        pixel_queue.push_back('{8'd0, 8'd255, 8'd0});
        pixel_queue.push_back('{8'd0, 8'd0, 8'd255});
        pixel_queue.push_back('{8'd128, 8'd64, 8'd1});
        drain();

        // pixels below the first stop, zero-width and descending segments, no segment
        write_reg(CFG_STOPS_01, {32'h60_00FF80, 32'h40_FF0010});
        write_reg(CFG_STOPS_23, {32'h30_123456, 32'h60_AABBCC});
        write_reg(CFG_STOPS_45, {32'hFF_FFFFFF, 32'h90_000000});
        write_reg(CFG_STOPS_67, {32'h00_010203, 32'hFF_808080});
        write_reg(CFG_STOP_COUNT, 4'd15);
        for (int v = 0; v < 256; v += 37)
            pixel_queue.push_back('{8'(v), 8'(v), 8'(255 - v)});
        pixel_queue.push_back('{8'd0, 8'd0, 8'd0});
        pixel_queue.push_back('{8'd255, 8'd255, 8'd255});
        drain();
        write_reg(CFG_STOP_COUNT, 4'd1);
        pixel_queue.push_back('{8'd10, 8'd20, 8'd30});
        drain();
        write_reg(CFG_STOP_COUNT, 4'd0);
        pixel_queue.push_back('{8'd0, 8'd0, 8'd0});
        drain();
        write_reg(CFG_STOPS_01, '1);
        write_reg(CFG_STOP_COUNT, 4'd2);
        pixel_queue.push_back('{8'd255, 8'd255, 8'd255});
        pixel_queue.push_back('{8'd1, 8'd0, 8'd0});
        drain();

        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            random_ramp(ph == 0 ? 8 : ph == 1 ? 2 : $urandom_range(15));
            in_gaps = (ph != 3);
            out_gaps = (ph != 3);
            if (ph == 5) hold_cycles = 200;
            for (int k = 0; k < 210; k++) pixel_queue.push_back(rand_pixel());
            drain();
        end
        in_gaps = 1'b1;
        out_gaps = 1'b1;

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
